// File: sv/accumulator_bytecode_scan_engine_defines.svh
// Assertion macros used by the scan engine's result queue.
`ifndef ACCUMULATOR_BYTECODE_SCAN_ENGINE_DEFINES_SVH
`define ACCUMULATOR_BYTECODE_SCAN_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ABSE_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant violated");

`define ABSE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication violated");

`define ABSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ABSE_ASSERT_ALWAYS(label, clk, rstn, cond)
`define ABSE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ABSE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: sv/abse_pkg.sv
// Types, codes and sizes shared by the scan engine files.
`default_nettype none

package abse_pkg;

    localparam int INPUT_DEPTH = 256;
    localparam int REG_DEPTH   = 256;
    localparam int INPUT_AW    = $clog2(INPUT_DEPTH);
    localparam int REG_AW      = $clog2(REG_DEPTH);

    // Result queue.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef enum logic [7:0] {
        OPC_END     = 8'h00,
        OPC_LD_IN   = 8'h10,
        OPC_LD_REG  = 8'h11,
        OPC_ST_REG  = 8'h12,
        OPC_ST_OUT  = 8'h13,
        OPC_LD_IMM  = 8'h20,
        OPC_ADD_IMM = 8'h21
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_BADOP  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_INPUT = 2'd0,
        MODE_REG   = 2'd1,
        MODE_CODE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_INPUT_COUNT  = 2'd0,
        CFG_REG_COUNT    = 2'd1,
        CFG_OUTPUT_COUNT = 2'd2
    } cfg_index_t;

    localparam logic KIND_OUTPUT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] out_index;
        logic [31:0] out_value;
        logic [1:0]  status;
    } result_t;

    // Results produced by one transaction: count, then up to two items in order.
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t mk_status(status_t st);
        result_t r;
        r.kind      = KIND_STATUS;
        r.out_index = '0;
        r.out_value = '0;
        r.status    = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/abse_if.sv
// Channel interfaces: program/host items in, result items out.
`default_nettype none

interface abse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  point_index;
    logic signed [31:0] point_value;
    logic [7:0]  code_byte;
    logic        code_last;

    modport source (output valid, mode, point_index, point_value, code_byte, code_last,
                    input ready);
    modport sink   (input valid, mode, point_index, point_value, code_byte, code_last,
                    output ready);
endinterface

interface abse_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] out_index;
    logic signed [31:0] out_value;
    logic [1:0]  status;

    modport source (output valid, kind, out_index, out_value, status, input ready);
    modport sink   (input valid, kind, out_index, out_value, status, output ready);
endinterface

`default_nettype wire

// File: sv/abse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module abse_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/abse_result_queue.sv
// Four-entry result queue that decouples the engine from a stalling receiver.
`default_nettype none
`include "accumulator_bytecode_scan_engine_defines.svh"

module abse_result_queue
    import abse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire push_t push,
    output logic      room,
    abse_out_if.source result
);

    result_t            entries [RQ_DEPTH];
    logic [RQ_AW-1:0]   head_reg, head_next;
    logic [RQ_AW-1:0]   tail_reg, tail_next;
    logic [RQ_CW-1:0]   count_reg, count_next;
    logic               pop;
    result_t            head_item;

    assign pop       = result.valid && result.ready;
    assign head_item = entries[head_reg];

    // Room for the two results that the worst transaction can produce.
    assign room = (count_reg <= RQ_CW'(RQ_DEPTH - 2));

    assign result.valid     = (count_reg != '0);
    assign result.kind      = head_item.kind;
    assign result.out_index = head_item.out_index;
    assign result.out_value = head_item.out_value;
    assign result.status    = head_item.status;

    always_comb
    begin
        head_next  = pop ? RQ_AW'(head_reg + 1'b1) : head_reg;
        tail_next  = RQ_AW'(tail_reg + RQ_AW'(push.n));
        count_next = RQ_CW'(count_reg + RQ_CW'(push.n) - RQ_CW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entries[tail_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            entries[RQ_AW'(tail_reg + 1'b1)] <= push.second;
        end
    end

    `ABSE_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= RQ_CW'(RQ_DEPTH))
    `ABSE_ASSERT_IMPL(a_push_fits, clk, rst_n, push.n != 2'd0, ({1'b0, count_reg} + (RQ_CW + 1)'(push.n)) <= (RQ_CW + 1)'(RQ_DEPTH))
    `ABSE_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && (push.n == 2'd0), count_reg == RQ_CW'($past(count_reg) - 1'b1))

endmodule

`default_nettype wire

// File: sv/accumulator_bytecode_scan_engine.sv
// Accumulator byte-code scan engine: top level.
//
// Channel prog carries one transaction per cycle while prog.ready is high:
// mode 0 writes an input point, mode 1 writes a retained register, mode 2
// delivers one program byte (code_last marks the final byte). Channel result
// carries output-point writes (kind 0) and the scan status (kind 1). The port
// wr_en/wr_index/wr_data sets the three bound counts; the user is to use it
// only while the engine is idle, which the block does not enforce. Each byte
// is decoded in the cycle it is accepted; its results are in the result queue
// on the next edge, so result.valid is high in the cycle after the transaction
// that caused them. A load reads its table in the accepting cycle; the data
// reaches the accumulator in the next cycle, well before any opcode needs it.
// A four-entry result queue lets prog keep flowing while result stalls;
// prog.ready falls only when fewer than two queue entries are free.
// Reset clears the counts, the scan state and the register-file valid bits
// (unwritten registers read as zero); the input table is not cleared and
// there is no clearing pass, so the engine is ready in the first cycle.
`default_nettype none

module accumulator_bytecode_scan_engine
    import abse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    abse_in_if.sink          prog,
    abse_out_if.source       result
);

    localparam logic SRC_INPUT = 1'b0;
    localparam logic SRC_REG   = 1'b1;

    logic [8:0]  input_count_reg;
    logic [8:0]  register_count_reg;
    logic [15:0] output_count_reg;

    logic [31:0]      acc_reg, acc_next;
    opcode_t          op_reg, op_next;
    logic [2:0]       left_reg, left_next;
    logic [31:0]      shift_reg, shift_next;
    logic             fin_reg, fin_next;
    logic             load_pend_reg, load_pend_next;
    logic             ld_src_reg, ld_src_next;
    logic             rf_hit_reg;
    logic [REG_DEPTH-1:0] rf_valid_reg;

    logic                accept;
    logic                room;
    push_t               push;
    logic [31:0]         acc_cur;
    logic [31:0]         in_rdata;
    logic [31:0]         rf_rdata;
    logic [31:0]         ld_data;

    logic                in_we;
    logic                rf_we;
    logic [REG_AW-1:0]   rf_waddr;
    logic [31:0]         rf_wdata;
    logic [INPUT_AW-1:0] in_raddr;
    logic [REG_AW-1:0]   rf_raddr;

    assign prog.ready = room;
    assign accept     = prog.valid && prog.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg    <= '0;
            register_count_reg <= '0;
            output_count_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_INPUT_COUNT:  input_count_reg    <= wr_data[8:0];
                CFG_REG_COUNT:    register_count_reg <= wr_data[8:0];
                CFG_OUTPUT_COUNT: output_count_reg   <= wr_data;
                default: ;
            endcase
        end
    end

    // Loaded data lands in the accumulator in the cycle after the read.
    assign ld_data = (ld_src_reg == SRC_INPUT) ? in_rdata
                   : (rf_hit_reg ? rf_rdata : 32'd0);
    assign acc_cur = load_pend_reg ? ld_data : acc_reg;

    always_comb
    begin
        logic        imm_op;
        logic [1:0]  pos;
        logic [31:0] operand;
        logic [15:0] idx;
        logic [2:0]  left_dec;
        logic        fin_now;
        logic [1:0]  n;
        result_t     st_res;
        logic        give_status;

        acc_next       = acc_cur;
        op_next        = op_reg;
        left_next      = left_reg;
        shift_next     = shift_reg;
        fin_next       = fin_reg;
        load_pend_next = 1'b0;
        ld_src_next    = ld_src_reg;

        in_we    = 1'b0;
        rf_we    = 1'b0;
        rf_waddr = prog.point_index[REG_AW-1:0];
        rf_wdata = prog.point_value;

        imm_op   = (op_reg == OPC_LD_IMM) || (op_reg == OPC_ADD_IMM);
        pos      = imm_op ? 2'(3'd4 - left_reg) : 2'(3'd2 - left_reg);
        operand  = shift_reg | ({24'd0, prog.code_byte} << {pos, 3'b000});
        idx      = operand[15:0];
        left_dec = 3'(left_reg - 1'b1);
        in_raddr = idx[INPUT_AW-1:0];
        rf_raddr = idx[REG_AW-1:0];

        fin_now     = fin_reg;
        n           = 2'd0;
        give_status = 1'b0;
        st_res      = mk_status(ST_OK);

        push.n      = 2'd0;
        push.first  = mk_status(ST_OK);
        push.second = mk_status(ST_OK);

        if (accept)
        begin
            unique case (mode_t'(prog.mode))
                MODE_INPUT:
                begin
                    in_we = 1'b1;
                end
                MODE_REG:
                begin
                    rf_we = 1'b1;
                end
                MODE_CODE:
                begin
                    if (!fin_reg)
                    begin
                        if (left_reg == 3'd0)
                        begin
                            unique case (opcode_t'(prog.code_byte))
                                OPC_END:
                                begin
                                    give_status = 1'b1;
                                    st_res      = mk_status(ST_OK);
                                end
                                OPC_LD_IN, OPC_LD_REG, OPC_ST_REG, OPC_ST_OUT:
                                begin
                                    op_next    = opcode_t'(prog.code_byte);
                                    left_next  = 3'd2;
                                    shift_next = '0;
                                end
                                OPC_LD_IMM, OPC_ADD_IMM:
                                begin
                                    op_next    = opcode_t'(prog.code_byte);
                                    left_next  = 3'd4;
                                    shift_next = '0;
                                end
                                default:
                                begin
                                    give_status = 1'b1;
                                    st_res      = mk_status(ST_BADOP);
                                end
                            endcase
                        end
                        else
                        begin
                            shift_next = operand;
                            left_next  = left_dec;
                            if (left_dec == 3'd0)
                            begin
                                case (op_reg)
                                    OPC_LD_IN:
                                    begin
                                        if ((idx >= 16'(input_count_reg)) ||
                                            ({1'b0, idx} >= 17'(INPUT_DEPTH)))
                                        begin
                                            give_status = 1'b1;
                                            st_res      = mk_status(ST_BOUNDS);
                                        end
                                        else
                                        begin
                                            load_pend_next = 1'b1;
                                            ld_src_next    = SRC_INPUT;
                                        end
                                    end
                                    OPC_LD_REG:
                                    begin
                                        if ((idx >= 16'(register_count_reg)) ||
                                            ({1'b0, idx} >= 17'(REG_DEPTH)))
                                        begin
                                            give_status = 1'b1;
                                            st_res      = mk_status(ST_BOUNDS);
                                        end
                                        else
                                        begin
                                            load_pend_next = 1'b1;
                                            ld_src_next    = SRC_REG;
                                        end
                                    end
                                    OPC_ST_REG:
                                    begin
                                        if ((idx >= 16'(register_count_reg)) ||
                                            ({1'b0, idx} >= 17'(REG_DEPTH)))
                                        begin
                                            give_status = 1'b1;
                                            st_res      = mk_status(ST_BOUNDS);
                                        end
                                        else
                                        begin
                                            rf_we    = 1'b1;
                                            rf_waddr = idx[REG_AW-1:0];
                                            rf_wdata = acc_cur;
                                        end
                                    end
                                    OPC_ST_OUT:
                                    begin
                                        if (idx >= output_count_reg)
                                        begin
                                            give_status = 1'b1;
                                            st_res      = mk_status(ST_BOUNDS);
                                        end
                                        else
                                        begin
                                            push.first.kind      = KIND_OUTPUT;
                                            push.first.out_index = idx;
                                            push.first.out_value = acc_cur;
                                            push.first.status    = ST_OK;
                                            n = 2'd1;
                                        end
                                    end
                                    OPC_LD_IMM:
                                    begin
                                        acc_next = operand;
                                    end
                                    default:
                                    begin
                                        acc_next = 32'(acc_cur + operand);
                                    end
                                endcase
                            end
                        end

                        // At most one status per byte: an error ends the scan,
                        // otherwise the last byte reports a missing END.
                        if (give_status)
                        begin
                            fin_now = 1'b1;
                        end
                        else if (prog.code_last)
                        begin
                            give_status = 1'b1;
                            st_res      = mk_status(ST_BOUNDS);
                            fin_now     = 1'b1;
                        end

                        if (give_status)
                        begin
                            if (n == 2'd0)
                            begin
                                push.first = st_res;
                            end
                            else
                            begin
                                push.second = st_res;
                            end
                            n = 2'(n + 1'b1);
                        end
                        push.n   = n;
                        fin_next = fin_now;
                    end

                    if (prog.code_last)
                    begin
                        acc_next       = '0;
                        op_next        = OPC_END;
                        left_next      = '0;
                        shift_next     = '0;
                        fin_next       = 1'b0;
                        load_pend_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            op_reg        <= OPC_END;
            left_reg      <= '0;
            shift_reg     <= '0;
            fin_reg       <= 1'b0;
            load_pend_reg <= 1'b0;
            ld_src_reg    <= SRC_INPUT;
            rf_valid_reg  <= '0;
        end
        else
        begin
            acc_reg       <= acc_next;
            op_reg        <= op_next;
            left_reg      <= left_next;
            shift_reg     <= shift_next;
            fin_reg       <= fin_next;
            load_pend_reg <= load_pend_next;
            ld_src_reg    <= ld_src_next;
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    // Valid bit is sampled alongside the register-file read.
    always_ff @(posedge clk)
    begin
        rf_hit_reg <= rf_valid_reg[rf_raddr];
    end

    abse_ram #(
        .DEPTH (INPUT_DEPTH),
        .WIDTH (32)
    ) u_input_table (
        .clk   (clk),
        .we    (in_we),
        .waddr (prog.point_index[INPUT_AW-1:0]),
        .wdata (prog.point_value),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    abse_ram #(
        .DEPTH (REG_DEPTH),
        .WIDTH (32)
    ) u_register_file (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    abse_result_queue u_result_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

`default_nettype wire
